FILE: rtl/link_delay_bandwidth_emulator_top_defines.svh
// Assertion macros for the link delay and bandwidth emulator.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef LINK_DELAY_BANDWIDTH_EMULATOR_TOP_DEFINES_SVH
`define LINK_DELAY_BANDWIDTH_EMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LDBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LDBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ldbe_pkg.sv
// Package for the link delay and bandwidth emulator: widths, constants,
// codes, sequencer states and the result record. No dependencies.
`default_nettype none

package ldbe_pkg;

  // Field widths.
  localparam int unsigned BW_W       = 48;
  localparam int unsigned LAT_W      = 32;
  localparam int unsigned LOSS_W     = 17;
  localparam int unsigned NOW_W      = 48;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned RND_W      = 16;
  localparam int unsigned FLIGHT_W   = 22;
  localparam int unsigned DELAY_W    = 31;
  localparam int unsigned RES_W      = 64;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 48;

  // Pending-length queue.
  localparam int unsigned PENDING_DEPTH = 64;
  localparam int unsigned PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned PEND_CW = $clog2(PENDING_DEPTH + 1);

  // Serialization time: body_length * 1000 / bandwidth.
  localparam int unsigned SER_SCALE  = 1000;
  localparam int unsigned DIVIDEND_W = 26;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Capacity check: in-flight plus one frame fits in 23 bits.
  localparam int unsigned NEED_W = FLIGHT_W + 1;
  localparam int unsigned MUL_W  = NEED_W;

  localparam logic [FLIGHT_W-1:0] FLIGHT_MAX = '1;
  localparam logic [BW_W-1:0]     BW_RESET   = BW_W'(64'd10 * 64'd1024 * 64'd1024 * 64'd1024);
  localparam logic [LAT_W-1:0]    LAT_RESET  = LAT_W'(10);

  typedef enum logic {
    KIND_SEND    = 1'b0,
    KIND_DELIVER = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_LINK_DOWN  = 3'd1,
    CAUSE_LOSS       = 3'd2,
    CAUSE_CAPACITY   = 3'd3,
    CAUSE_QUEUE_FULL = 3'd4
  } cause_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANDWIDTH    = 8'd0,
    CFG_LATENCY      = 8'd1,
    CFG_LOSS         = 8'd2,
    CFG_LINK_ENABLED = 8'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CAP,
    S_DIV,
    S_RESV,
    S_DELTA,
    S_DELAY,
    S_POP
  } state_e;

  typedef struct packed {
    logic                accepted;
    cause_e              drop_cause;
    logic [DELAY_W-1:0]  release_delay_ms;
    logic [LEN_W-1:0]    delivered_length;
    logic                underrun;
    logic [FLIGHT_W-1:0] bytes_in_flight;
  } rsp_t;

  typedef struct packed {
    logic load_rsp;
    logic div_start;
    logic ram_re;
    logic push;
    logic pop;
    logic resv_en;
    logic delta_en;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/ldbe_if.sv
// Channel interfaces of the link emulator: request, result and register write.
// Widths come from ldbe_pkg.
`default_nettype none

interface ldbe_req_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ldbe_pkg::NOW_W-1:0]  now_ms;
  logic [ldbe_pkg::LEN_W-1:0]  wire_length;
  logic [ldbe_pkg::LEN_W-1:0]  body_length;
  logic [ldbe_pkg::RND_W-1:0]  random_value;

  modport source (output valid, kind, now_ms, wire_length, body_length, random_value,
                  input ready);
  modport sink   (input valid, kind, now_ms, wire_length, body_length, random_value,
                  output ready);
endinterface

interface ldbe_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [2:0]                     drop_cause;
  logic [ldbe_pkg::DELAY_W-1:0]   release_delay_ms;
  logic [ldbe_pkg::LEN_W-1:0]     delivered_length;
  logic                           underrun;
  logic [ldbe_pkg::FLIGHT_W-1:0]  bytes_in_flight;

  modport source (output valid, accepted, drop_cause, release_delay_ms, delivered_length,
                  underrun, bytes_in_flight, input ready);
  modport sink   (input valid, accepted, drop_cause, release_delay_ms, delivered_length,
                  underrun, bytes_in_flight, output ready);
endinterface

interface ldbe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ldbe_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [ldbe_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/ldbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ldbe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ldbe_divider.sv
// Iterative restoring divider, one quotient bit per cycle, for the
// serialization time. Depends on ldbe_pkg.
`default_nettype none

module ldbe_divider (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [ldbe_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [ldbe_pkg::BW_W-1:0]         divisor_i,
  output logic                                   done_o,
  output logic      [ldbe_pkg::DIVIDEND_W-1:0]   quotient_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [ldbe_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [ldbe_pkg::BW_W-1:0]           rem_q, rem_d;
  logic [ldbe_pkg::DIVIDEND_W-1:0]     quo_q, quo_d;
  logic [ldbe_pkg::BW_W:0]             trial;
  logic [ldbe_pkg::BW_W:0]             diff;
  logic                                fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q, quo_q[ldbe_pkg::DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = (trial >= {1'b0, divisor_i});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ldbe_pkg::DIV_CNT_W'(ldbe_pkg::DIVIDEND_W);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[ldbe_pkg::BW_W-1:0] : trial[ldbe_pkg::BW_W-1:0];
      quo_d = {quo_q[ldbe_pkg::DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - ldbe_pkg::DIV_CNT_W'(1);
      if (cnt_q == ldbe_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/link_delay_bandwidth_emulator_top.sv
// Link emulator: an admitted send runs check, capacity, divide (one-bit-per-cycle divider),
// reservation, delta and delay steps to a registered result; link, loss or queue drops end in
// the check step, a capacity drop in the capacity step; a deliver on an empty queue ends in
// check, else in pop after a registered queue read. A result held downstream adds its wait.
// One item is worked on at a time; the next is taken the cycle after the result is registered.
// Reset (rst_ni, asynchronous, active low) restores register defaults, empties the queue
// and clears the in-flight count and reservation time; queue storage is not cleared.
`default_nettype none
`include "link_delay_bandwidth_emulator_top_defines.svh"

module link_delay_bandwidth_emulator_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ldbe_req_if.sink    req_i,
  ldbe_rsp_if.source  rsp_o,
  ldbe_cfg_if.sink    cfg_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the user must issue them only while
  // the block is idle, so no item sees a change mid-flight; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [ldbe_pkg::BW_W-1:0]   bw_q;
  logic [ldbe_pkg::LAT_W-1:0]  lat_q;
  logic [ldbe_pkg::LOSS_W-1:0] loss_q;
  logic                        link_en_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q      <= ldbe_pkg::BW_RESET;
      lat_q     <= ldbe_pkg::LAT_RESET;
      loss_q    <= '0;
      link_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (ldbe_pkg::cfg_reg_e'(cfg_i.reg_index))
        ldbe_pkg::CFG_BANDWIDTH:    bw_q      <= cfg_i.wdata[ldbe_pkg::BW_W-1:0];
        ldbe_pkg::CFG_LATENCY:      lat_q     <= cfg_i.wdata[ldbe_pkg::LAT_W-1:0];
        ldbe_pkg::CFG_LOSS:         loss_q    <= cfg_i.wdata[ldbe_pkg::LOSS_W-1:0];
        ldbe_pkg::CFG_LINK_ENABLED: link_en_q <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and the item captured at acceptance.
  // ---------------------------------------------------------------------------
  ldbe_pkg::state_e state_q, state_d;
  ldbe_pkg::ctrl_t  ctrl;
  ldbe_pkg::rsp_t   rsp_q, rsp_d;
  logic             out_valid_q;
  logic             fin_ok;

  ldbe_pkg::kind_e                kind_q;
  logic [ldbe_pkg::NOW_W-1:0]     now_q;
  logic [ldbe_pkg::LEN_W-1:0]     wire_q;
  logic [ldbe_pkg::LEN_W-1:0]     body_q;
  logic [ldbe_pkg::RND_W-1:0]     rnd_q;

  // Link state: in-flight count, reservation time and the length queue.
  logic [ldbe_pkg::FLIGHT_W-1:0]  inflight_q;
  logic [ldbe_pkg::RES_W-1:0]     res_q;
  logic [ldbe_pkg::RES_W-1:0]     delta_q;
  logic                           borrow_q;
  logic [ldbe_pkg::PEND_AW-1:0]   head_q, tail_q;
  logic [ldbe_pkg::PEND_CW-1:0]   count_q;
  logic [ldbe_pkg::LEN_W-1:0]     ram_rdata;

  logic [2*ldbe_pkg::MUL_W-1:0]   prod_q;

  // The request side is ready only between items; the result register lets
  // the next item start while the previous result still waits downstream.
  assign req_i.ready = (state_q == ldbe_pkg::S_IDLE);
  assign fin_ok      = !out_valid_q || rsp_o.ready;

  // ---------------------------------------------------------------------------
  // Derived values used by the sequencer.
  // ---------------------------------------------------------------------------
  logic [ldbe_pkg::BW_W-1:0]       bw_eff;
  logic [ldbe_pkg::NEED_W-1:0]     need;
  logic [ldbe_pkg::FLIGHT_W-1:0]   inflight_add;
  logic [ldbe_pkg::FLIGHT_W-1:0]   inflight_sub;
  logic                            link_down;
  logic                            loss_hit;
  logic                            queue_full;
  logic                            queue_empty;
  logic                            cap_drop;
  logic [ldbe_pkg::DIVIDEND_W-1:0] dividend;
  logic                            div_done;
  logic [ldbe_pkg::DIVIDEND_W-1:0] ser_ms;
  logic [ldbe_pkg::RES_W-1:0]      res_base;
  logic [ldbe_pkg::RES_W:0]        delta_full;
  logic [ldbe_pkg::DELAY_W+1:0]    delay_sum;
  logic [ldbe_pkg::DELAY_W-1:0]    delay_val;

  always_comb begin
    // A zero bandwidth behaves as one byte per second for both uses.
    bw_eff = (bw_q == '0) ? ldbe_pkg::BW_W'(1) : bw_q;
    need   = ldbe_pkg::NEED_W'(inflight_q) + ldbe_pkg::NEED_W'(wire_q);
    inflight_add = need[ldbe_pkg::NEED_W-1] ? ldbe_pkg::FLIGHT_MAX
                                            : need[ldbe_pkg::FLIGHT_W-1:0];
    inflight_sub = (inflight_q > ldbe_pkg::FLIGHT_W'(ram_rdata))
                   ? inflight_q - ldbe_pkg::FLIGHT_W'(ram_rdata) : '0;

    link_down   = !link_en_q;
    loss_hit    = ({1'b0, rnd_q} < loss_q);
    queue_full  = (count_q >= ldbe_pkg::PEND_CW'(ldbe_pkg::PENDING_DEPTH));
    queue_empty = (count_q == '0);

    // The capacity test only bites when bandwidth is below the need, so both
    // bandwidth and a relevant latency fit in 23 bits and the product cannot wrap.
    // A latency at or above 2^23 always leaves room.
    cap_drop = (lat_q != '0)
            && (bw_eff < ldbe_pkg::BW_W'(need))
            && (lat_q[ldbe_pkg::LAT_W-1:ldbe_pkg::MUL_W] == '0)
            && ((2*ldbe_pkg::MUL_W)'(need) > prod_q);

    dividend = ldbe_pkg::DIVIDEND_W'(body_q) * ldbe_pkg::DIVIDEND_W'(ldbe_pkg::SER_SCALE);

    // Reservation never moves back when time does.
    res_base = (res_q < ldbe_pkg::RES_W'(now_q)) ? ldbe_pkg::RES_W'(now_q) : res_q;
    delta_full = {1'b0, res_q} - {1'b0, ldbe_pkg::RES_W'(now_q)};

    // Delay is the distance to the reservation plus latency, saturated; a
    // reservation that wrapped below now also saturates.
    delay_sum = (ldbe_pkg::DELAY_W+2)'(delta_q[ldbe_pkg::DELAY_W-1:0])
              + (ldbe_pkg::DELAY_W+2)'(lat_q);
    if (borrow_q || (delta_q[ldbe_pkg::RES_W-1:ldbe_pkg::DELAY_W] != '0)
        || (delay_sum[ldbe_pkg::DELAY_W+1:ldbe_pkg::DELAY_W] != '0)) begin
      delay_val = '1;
    end else begin
      delay_val = delay_sum[ldbe_pkg::DELAY_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Next-state logic.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldbe_pkg::S_IDLE: begin
        if (req_i.valid) begin
          state_d = ldbe_pkg::S_CHECK;
        end
      end
      ldbe_pkg::S_CHECK: begin
        if (kind_q == ldbe_pkg::KIND_DELIVER) begin
          if (!queue_empty) begin
            state_d = ldbe_pkg::S_POP;
          end else if (fin_ok) begin
            state_d = ldbe_pkg::S_IDLE;
          end
        end else if (link_down || loss_hit || queue_full) begin
          if (fin_ok) begin
            state_d = ldbe_pkg::S_IDLE;
          end
        end else begin
          state_d = ldbe_pkg::S_CAP;
        end
      end
      ldbe_pkg::S_CAP: begin
        if (!cap_drop) begin
          state_d = ldbe_pkg::S_DIV;
        end else if (fin_ok) begin
          state_d = ldbe_pkg::S_IDLE;
        end
      end
      ldbe_pkg::S_DIV: begin
        if (div_done) begin
          state_d = ldbe_pkg::S_RESV;
        end
      end
      ldbe_pkg::S_RESV:  state_d = ldbe_pkg::S_DELTA;
      ldbe_pkg::S_DELTA: state_d = ldbe_pkg::S_DELAY;
      ldbe_pkg::S_DELAY, ldbe_pkg::S_POP: begin
        if (fin_ok) begin
          state_d = ldbe_pkg::S_IDLE;
        end
      end
      default: state_d = ldbe_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: control strobes and the result to be registered.
  // A finishing state only commits when the result register is free.
  // ---------------------------------------------------------------------------
  always_comb begin
    ctrl  = '0;
    rsp_d = '0;
    rsp_d.drop_cause      = ldbe_pkg::CAUSE_NONE;
    rsp_d.bytes_in_flight = inflight_q;
    unique case (state_q)
      ldbe_pkg::S_CHECK: begin
        if (kind_q == ldbe_pkg::KIND_DELIVER) begin
          if (queue_empty) begin
            rsp_d.underrun = 1'b1;
            ctrl.load_rsp  = fin_ok;
          end else begin
            ctrl.ram_re = 1'b1;
          end
        end else if (link_down) begin
          rsp_d.drop_cause = ldbe_pkg::CAUSE_LINK_DOWN;
          ctrl.load_rsp    = fin_ok;
        end else if (loss_hit) begin
          rsp_d.drop_cause = ldbe_pkg::CAUSE_LOSS;
          ctrl.load_rsp    = fin_ok;
        end else if (queue_full) begin
          rsp_d.drop_cause = ldbe_pkg::CAUSE_QUEUE_FULL;
          ctrl.load_rsp    = fin_ok;
        end
      end
      ldbe_pkg::S_CAP: begin
        if (cap_drop) begin
          rsp_d.drop_cause = ldbe_pkg::CAUSE_CAPACITY;
          ctrl.load_rsp    = fin_ok;
        end else begin
          ctrl.div_start = 1'b1;
        end
      end
      ldbe_pkg::S_RESV:  ctrl.resv_en  = 1'b1;
      ldbe_pkg::S_DELTA: ctrl.delta_en = 1'b1;
      ldbe_pkg::S_DELAY: begin
        rsp_d.accepted         = 1'b1;
        rsp_d.release_delay_ms = delay_val;
        rsp_d.bytes_in_flight  = inflight_add;
        ctrl.load_rsp          = fin_ok;
        ctrl.push              = fin_ok;
      end
      ldbe_pkg::S_POP: begin
        rsp_d.delivered_length = ram_rdata;
        rsp_d.bytes_in_flight  = inflight_sub;
        ctrl.load_rsp          = fin_ok;
        ctrl.pop               = fin_ok;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldbe_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      inflight_q  <= '0;
      res_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.load_rsp) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl.resv_en) begin
        res_q <= res_base + ldbe_pkg::RES_W'(ser_ms);
      end
      if (ctrl.push) begin
        inflight_q <= inflight_add;
        tail_q     <= (tail_q == ldbe_pkg::PEND_AW'(ldbe_pkg::PENDING_DEPTH - 1))
                      ? '0 : tail_q + ldbe_pkg::PEND_AW'(1);
        count_q    <= count_q + ldbe_pkg::PEND_CW'(1);
      end else if (ctrl.pop) begin
        inflight_q <= inflight_sub;
        head_q     <= (head_q == ldbe_pkg::PEND_AW'(ldbe_pkg::PENDING_DEPTH - 1))
                      ? '0 : head_q + ldbe_pkg::PEND_AW'(1);
        count_q    <= count_q - ldbe_pkg::PEND_CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      kind_q <= ldbe_pkg::kind_e'(req_i.kind);
      now_q  <= req_i.now_ms;
      wire_q <= req_i.wire_length;
      body_q <= req_i.body_length;
      rnd_q  <= req_i.random_value;
    end
    if (state_q == ldbe_pkg::S_CHECK) begin
      prod_q <= bw_eff[ldbe_pkg::MUL_W-1:0] * lat_q[ldbe_pkg::MUL_W-1:0];
    end
    if (ctrl.delta_en) begin
      delta_q  <= delta_full[ldbe_pkg::RES_W-1:0];
      borrow_q <= delta_full[ldbe_pkg::RES_W];
    end
    if (ctrl.load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider for the serialization time and the length queue memory.
  // ---------------------------------------------------------------------------
  ldbe_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (dividend),
    .divisor_i  (bw_eff),
    .done_o     (div_done),
    .quotient_o (ser_ms)
  );

  ldbe_ram #(
    .WIDTH (ldbe_pkg::LEN_W),
    .DEPTH (ldbe_pkg::PENDING_DEPTH)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.push),
    .waddr_i (tail_q),
    .wdata_i (wire_q),
    .re_i    (ctrl.ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result channel.
  // ---------------------------------------------------------------------------
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.accepted         = rsp_q.accepted;
  assign rsp_o.drop_cause       = rsp_q.drop_cause;
  assign rsp_o.release_delay_ms = rsp_q.release_delay_ms;
  assign rsp_o.delivered_length = rsp_q.delivered_length;
  assign rsp_o.underrun         = rsp_q.underrun;
  assign rsp_o.bytes_in_flight  = rsp_q.bytes_in_flight;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `LDBE_ASSERT_IMP(a_count_bound, 1'b1,
                   count_q <= ldbe_pkg::PEND_CW'(ldbe_pkg::PENDING_DEPTH),
                   "queue count above depth")
  `LDBE_ASSERT_IMP(a_ptr_align, (count_q == '0) ||
                   (count_q == ldbe_pkg::PEND_CW'(ldbe_pkg::PENDING_DEPTH)),
                   head_q == tail_q, "queue pointers out of step with count")
  `LDBE_ASSERT_IMP(a_div_owner, div_done, state_q == ldbe_pkg::S_DIV,
                   "divider finished outside the divide step")
  `LDBE_ASSERT_NXT(a_accept_clean, ctrl.load_rsp && rsp_d.accepted,
                   rsp_q.drop_cause == ldbe_pkg::CAUSE_NONE && !rsp_q.underrun,
                   "admitted send carries a drop cause or underrun")

endmodule

`default_nettype wire
